[hw/rtl/sps_pkg.sv]
package sps_pkg;

    // Ceiling on the step period in ticks
    localparam int MAX_PERIOD_MS = 1000;

    localparam int MODE_W = 3;
    localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_JOG_CW   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_JOG_CCW  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HOME_CW  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_HOME_CCW = 3'd4;

    localparam logic [1:0] CFG_MOTOR_TYPE     = 2'd0;
    localparam logic [1:0] CFG_STEP_PERIOD_MS = 2'd1;
    localparam logic [1:0] CFG_MIN_HOME_STEPS = 2'd2;

    localparam logic [7:0]  COILS_OFF       = 8'hFF;
    localparam logic [11:0] STEP_MAX        = 12'hFFF;
    localparam logic [9:0]  PERIOD_RESET    = 10'd10;
    localparam logic [11:0] MIN_HOME_RESET  = 12'd200;

    localparam logic [7:0] HALF_CW  [8] = '{8'h09, 8'h0B, 8'h0A, 8'h0E,
                                            8'h06, 8'h07, 8'h05, 8'h0D};
    localparam logic [7:0] HALF_CCW [8] = '{8'h0D, 8'h05, 8'h07, 8'h06,
                                            8'h0E, 8'h0A, 8'h0B, 8'h09};
    localparam logic [7:0] FULL_CW  [4] = '{8'hF5, 8'hF9, 8'hFA, 8'hF6};
    localparam logic [7:0] FULL_CCW [4] = '{8'hF6, 8'hFA, 8'hF9, 8'hF5};

    typedef struct packed {
        logic        motor_type;
        logic [9:0]  step_period_ms;
        logic [11:0] min_home_steps;
    } sps_cfg_t;

    typedef struct packed {
        logic [MODE_W-1:0] run_mode;
        logic [2:0]        phase_index;
        logic [9:0]        tick_count;
        logic [11:0]       step_count;
        logic [7:0]        pattern;
    } sps_state_t;

    typedef struct packed {
        logic [7:0] coil_pattern;
        logic       moving;
        logic       direction;
        logic       step_strobe;
    } sps_result_t;

    function automatic logic is_ccw(input logic [MODE_W-1:0] mode);
        return (mode == MODE_JOG_CCW) || (mode == MODE_HOME_CCW);
    endfunction

    function automatic logic [7:0] table_entry(input logic half, input logic ccw,
                                               input logic [2:0] idx);
        logic [7:0] e;
        if (half)
            e = ccw ? HALF_CCW[idx] : HALF_CW[idx];
        else
            e = ccw ? FULL_CCW[idx[1:0]] : FULL_CW[idx[1:0]];
        return e;
    endfunction

endpackage

[hw/rtl/sps_cfg_regs.sv]
module sps_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [11:0]        cfg_data,
    output sps_pkg::sps_cfg_t  cfg
);

    sps_pkg::sps_cfg_t cfg_reg;
    sps_pkg::sps_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                sps_pkg::CFG_MOTOR_TYPE:     cfg_next.motor_type     = cfg_data[0];
                sps_pkg::CFG_STEP_PERIOD_MS: cfg_next.step_period_ms = cfg_data[9:0];
                sps_pkg::CFG_MIN_HOME_STEPS: cfg_next.min_home_steps = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.motor_type     <= 1'b0;
            cfg_reg.step_period_ms <= sps_pkg::PERIOD_RESET;
            cfg_reg.min_home_steps <= sps_pkg::MIN_HOME_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[hw/rtl/sps_step_logic.sv]
module sps_step_logic (
    input  sps_pkg::sps_cfg_t    cfg,
    input  sps_pkg::sps_state_t  state,
    input  logic                 run_enable,
    input  logic                 cw_request,
    input  logic                 ccw_request,
    input  logic                 sensor_mode,
    input  logic                 home_sensor,
    output sps_pkg::sps_state_t  state_next,
    output sps_pkg::sps_result_t result
);

    localparam int PERIOD_CAP = (sps_pkg::MAX_PERIOD_MS > 1023) ? 1023
                                                                : sps_pkg::MAX_PERIOD_MS;

    logic [9:0] period;

    // zero acts as one, anything above the cap saturates
    always_comb
    begin
        if (cfg.step_period_ms == 10'd0)
            period = 10'd1;
        else if ({6'd0, cfg.step_period_ms} > 16'(PERIOD_CAP))
            period = 10'(PERIOD_CAP);
        else
            period = cfg.step_period_ms;
    end

    always_comb
    begin
        sps_pkg::sps_state_t s;
        logic                strobe;
        logic                keep;
        logic [10:0]         tick_sum;
        logic [sps_pkg::MODE_W-1:0] start_mode;

        s          = state;
        strobe     = 1'b0;
        keep       = 1'b0;
        tick_sum   = {1'b0, state.tick_count} + 11'd1;
        start_mode = sps_pkg::MODE_IDLE;

        if (!run_enable)
        begin
            s.run_mode   = sps_pkg::MODE_IDLE;
            s.tick_count = 10'd0;
            s.pattern    = sps_pkg::COILS_OFF;
        end
        else
        begin
            if (s.run_mode != sps_pkg::MODE_IDLE)
            begin
                if (tick_sum >= {1'b0, period})
                begin
                    if (s.step_count != sps_pkg::STEP_MAX)
                        s.step_count = s.step_count + 12'd1;
                    case (s.run_mode)
                        sps_pkg::MODE_JOG_CW:  keep = cw_request && !sensor_mode;
                        sps_pkg::MODE_JOG_CCW: keep = ccw_request && !sensor_mode;
                        default:
                            keep = !(home_sensor && (s.step_count > cfg.min_home_steps));
                    endcase
                    if (keep)
                    begin
                        s.phase_index = (s.phase_index + 3'd1)
                                      & (cfg.motor_type ? 3'd7 : 3'd3);
                        s.pattern     = sps_pkg::table_entry(cfg.motor_type,
                                            sps_pkg::is_ccw(s.run_mode), s.phase_index);
                        s.tick_count  = 10'd0;
                        strobe        = 1'b1;
                    end
                    else
                    begin
                        s.run_mode   = sps_pkg::MODE_IDLE;
                        s.tick_count = 10'd0;
                        s.pattern    = sps_pkg::COILS_OFF;
                    end
                end
                else
                begin
                    s.tick_count = tick_sum[9:0];
                end
            end

            // a run that just ended may restart on the same tick
            if (s.run_mode == sps_pkg::MODE_IDLE)
            begin
                if (cw_request)
                    start_mode = sensor_mode ? sps_pkg::MODE_HOME_CW : sps_pkg::MODE_JOG_CW;
                else if (ccw_request)
                    start_mode = sensor_mode ? sps_pkg::MODE_HOME_CCW : sps_pkg::MODE_JOG_CCW;

                if (start_mode != sps_pkg::MODE_IDLE)
                begin
                    s.run_mode    = start_mode;
                    s.phase_index = 3'd0;
                    s.step_count  = 12'd0;
                    s.tick_count  = 10'd0;
                    s.pattern     = sps_pkg::table_entry(cfg.motor_type,
                                        sps_pkg::is_ccw(start_mode), 3'd0);
                    strobe        = 1'b1;
                end
                else
                begin
                    s.pattern = sps_pkg::COILS_OFF;
                end
            end
        end

        state_next          = s;
        result.coil_pattern = s.pattern;
        result.moving       = (s.run_mode != sps_pkg::MODE_IDLE);
        result.direction    = sps_pkg::is_ccw(s.run_mode);
        result.step_strobe  = strobe;
    end

endmodule

[hw/rtl/stepper_phase_sequencer.sv]
// A tick beat accepted into the input register moves into the result register, and so onto
// the outputs, once that slot frees up. Throughput: one tick beat per clock while the output
// is not stalled; the input and result registers keep the single state update between them.
// Reset (rst_n, async, active low): idle, coils 0xFF, counters zero, period 10 ms,
// motor type 0, minimum homing steps 200; both pipeline registers empty.
module stepper_phase_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        run_enable,
    input  logic        cw_request,
    input  logic        ccw_request,
    input  logic        sensor_mode,
    input  logic        home_sensor,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  coil_pattern,
    output logic        moving,
    output logic        direction,
    output logic        step_strobe,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    sps_pkg::sps_cfg_t    cfg;
    sps_pkg::sps_state_t  state_reg;
    sps_pkg::sps_state_t  state_next;
    sps_pkg::sps_result_t result_next;
    sps_pkg::sps_result_t result_reg;

    logic in_valid_reg;
    logic out_valid_reg;
    logic run_enable_reg;
    logic cw_request_reg;
    logic ccw_request_reg;
    logic sensor_mode_reg;
    logic home_sensor_reg;
    logic advance;
    logic in_take;

    sps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sps_step_logic u_step (
        .cfg         (cfg),
        .state       (state_reg),
        .run_enable  (run_enable_reg),
        .cw_request  (cw_request_reg),
        .ccw_request (ccw_request_reg),
        .sensor_mode (sensor_mode_reg),
        .home_sensor (home_sensor_reg),
        .state_next  (state_next),
        .result      (result_next)
    );

    // the held beat moves into the result register when that slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            state_reg.run_mode    <= sps_pkg::MODE_IDLE;
            state_reg.phase_index <= 3'd0;
            state_reg.tick_count  <= 10'd0;
            state_reg.step_count  <= 12'd0;
            state_reg.pattern     <= sps_pkg::COILS_OFF;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            run_enable_reg  <= run_enable;
            cw_request_reg  <= cw_request;
            ccw_request_reg <= ccw_request;
            sensor_mode_reg <= sensor_mode;
            home_sensor_reg <= home_sensor;
        end
        if (advance)
            result_reg <= result_next;
    end

    assign out_valid    = out_valid_reg;
    assign coil_pattern = result_reg.coil_pattern;
    assign moving       = result_reg.moving;
    assign direction    = result_reg.direction;
    assign step_strobe  = result_reg.step_strobe;

    a_idle_coils_off: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.run_mode == sps_pkg::MODE_IDLE) |-> (state_reg.pattern == sps_pkg::COILS_OFF))
        else $error("idle state holds a coil pattern other than all off");

    a_strobe_while_moving: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && step_strobe) |-> moving)
        else $error("step strobe without an active run");

    a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !moving) |-> (coil_pattern == sps_pkg::COILS_OFF && !direction))
        else $error("idle result with coils driven or direction set");

    a_state_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("run state changed without a tick beat");

endmodule

[dv/tb_stepper_phase_sequencer.sv]
`timescale 1ns / 1ps

module tb_stepper_phase_sequencer;

    typedef struct packed {
        logic run_enable;
        logic cw;
        logic ccw;
        logic sensor;
        logic home;
    } tick_t;

    typedef struct packed {
        logic                 is_cfg;
        logic [1:0]           reg_idx;
        logic [11:0]          reg_val;
        tick_t                t;
        logic                 typed;
        sps_pkg::sps_result_t want;
    } script_row_t;

    typedef struct packed {
        logic        motor;
        logic [9:0]  period;
        logic [11:0] min_home;
        int          items;
        int          churn;
        int          noise_pct;
    } phase_t;

    localparam sps_pkg::sps_result_t IDLE_OUT = '{sps_pkg::COILS_OFF, 1'b0, 1'b0, 1'b0};

    // Rows with typed results are simple enough to check by eye; the rest use the predictor.
    localparam script_row_t SCRIPT [28] = '{
        '{1'b0, '0, '0, 5'b01111, 1'b1, IDLE_OUT},                   // switch off wins
        '{1'b0, '0, '0, 5'b10000, 1'b1, IDLE_OUT},
        '{1'b1, sps_pkg::CFG_STEP_PERIOD_MS, 12'd1, '0, 1'b0, '0},
        '{1'b0, '0, '0, 5'b11100, 1'b1, '{8'hF5, 1'b1, 1'b0, 1'b1}},  // both held: cw wins
        '{1'b0, '0, '0, 5'b11000, 1'b1, '{8'hF9, 1'b1, 1'b0, 1'b1}},
        '{1'b0, '0, '0, 5'b11000, 1'b1, '{8'hFA, 1'b1, 1'b0, 1'b1}},
        '{1'b0, '0, '0, 5'b11000, 1'b1, '{8'hF6, 1'b1, 1'b0, 1'b1}},
        '{1'b0, '0, '0, 5'b11000, 1'b1, '{8'hF5, 1'b1, 1'b0, 1'b1}},  // table wrap
        '{1'b0, '0, '0, 5'b10100, 1'b1, '{8'hF6, 1'b1, 1'b1, 1'b1}},  // end and restart ccw
        '{1'b0, '0, '0, 5'b10110, 1'b0, '0},                          // homing ccw start
        '{1'b1, sps_pkg::CFG_MOTOR_TYPE, 12'd1, '0, 1'b0, '0},
        '{1'b0, '0, '0, 5'b10000, 1'b0, '0},                          // homing ignores buttons
        '{1'b0, '0, '0, 5'b10001, 1'b0, '0},
        '{1'b1, sps_pkg::CFG_MIN_HOME_STEPS, 12'd0, '0, 1'b0, '0},
        '{1'b0, '0, '0, 5'b10001, 1'b1, IDLE_OUT},                   // sensor stops homing
        '{1'b0, '0, '0, 5'b11010, 1'b0, '0},
        '{1'b0, '0, '0, 5'b10001, 1'b0, '0},
        '{1'b0, '0, '0, 5'b11010, 1'b0, '0},
        '{1'b0, '0, '0, 5'b01010, 1'b1, IDLE_OUT},                   // switch off mid homing
        '{1'b0, '0, '0, 5'b11000, 1'b0, '0},
        '{1'b0, '0, '0, 5'b11000, 1'b0, '0},
        '{1'b0, '0, '0, 5'b11000, 1'b0, '0},
        '{1'b0, '0, '0, 5'b11000, 1'b0, '0},
        '{1'b0, '0, '0, 5'b11000, 1'b0, '0},
        '{1'b1, sps_pkg::CFG_MOTOR_TYPE, 12'd0, '0, 1'b0, '0},       // table swap mid run
        '{1'b0, '0, '0, 5'b11000, 1'b0, '0},
        '{1'b1, sps_pkg::CFG_STEP_PERIOD_MS, 12'd0, '0, 1'b0, '0},   // zero period acts as 1
        '{1'b0, '0, '0, 5'b11000, 1'b0, '0}
    };

    localparam phase_t PHASES [8] = '{
        '{1'b0, 10'd10,   12'd200,  100, 8,  10},
        '{1'b1, 10'd1,    12'd0,    130, 6,  10},
        '{1'b0, 10'd2,    12'd3,    130, 6,  10},
        '{1'b1, 10'd3,    12'd7,    110, 10, 8},
        '{1'b0, 10'd0,    12'd1,    100, 5,  15},
        '{1'b1, 10'd5,    12'd4095, 80,  12, 5},
        '{1'b0, 10'd1000, 12'd2,    40,  20, 5},
        '{1'b1, 10'd1,    12'd12,   110, 8,  10}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        run_enable = 1'b0;
    logic        cw_request = 1'b0;
    logic        ccw_request = 1'b0;
    logic        sensor_mode = 1'b0;
    logic        home_sensor = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  coil_pattern;
    logic        moving;
    logic        direction;
    logic        step_strobe;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [11:0] cfg_data = '0;

    // predictor copy of the block
    logic                       half_step = 1'b0;
    logic [9:0]                 period_cfg = sps_pkg::PERIOD_RESET;
    logic [11:0]                home_min = sps_pkg::MIN_HOME_RESET;
    logic [sps_pkg::MODE_W-1:0] mode_q = sps_pkg::MODE_IDLE;
    logic [2:0]                 phase_q = '0;
    logic [9:0]                 ticks_q = '0;
    logic [11:0]                steps_q = '0;
    logic [7:0]                 coils_q = sps_pkg::COILS_OFF;

    sps_pkg::sps_result_t coil_beats_due [$];
    tick_t                lvl = 5'b10000;
    int                   tx_quiet = 0;
    int                   rx_quiet = 0;
    int                   errors = 0;

    stepper_phase_sequencer uut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic reverse_mode(input logic [sps_pkg::MODE_W-1:0] mode);
        return mode == sps_pkg::MODE_JOG_CCW || mode == sps_pkg::MODE_HOME_CCW;
    endfunction

    function automatic logic [7:0] coil_lookup(input logic [sps_pkg::MODE_W-1:0] mode,
                                               input logic [2:0] idx);
        if (half_step)
            return reverse_mode(mode) ? sps_pkg::HALF_CCW[idx] : sps_pkg::HALF_CW[idx];
        return reverse_mode(mode) ? sps_pkg::FULL_CCW[idx[1:0]] : sps_pkg::FULL_CW[idx[1:0]];
    endfunction

    function automatic sps_pkg::sps_result_t next_coil_beat(input tick_t t);
        logic [9:0]                 limit;
        logic                       keep;
        logic                       strobe;
        logic [sps_pkg::MODE_W-1:0] nxt;
        sps_pkg::sps_result_t       r;
        strobe = 1'b0;
        if (period_cfg == '0)
            limit = 10'd1;
        else if (period_cfg > sps_pkg::MAX_PERIOD_MS)
            limit = 10'(sps_pkg::MAX_PERIOD_MS);
        else
            limit = period_cfg;
        if (!t.run_enable)
        begin
            mode_q = sps_pkg::MODE_IDLE;
            ticks_q = '0;
            coils_q = sps_pkg::COILS_OFF;
        end
        else
        begin
            if (mode_q != sps_pkg::MODE_IDLE)
            begin
                ticks_q = ticks_q + 10'd1;
                if (ticks_q >= limit)
                begin
                    if (steps_q != sps_pkg::STEP_MAX)
                        steps_q = steps_q + 12'd1;
                    case (mode_q)
                        sps_pkg::MODE_JOG_CW:  keep = t.cw && !t.sensor;
                        sps_pkg::MODE_JOG_CCW: keep = t.ccw && !t.sensor;
                        default:               keep = !(t.home && steps_q > home_min);
                    endcase
                    ticks_q = '0;
                    if (keep)
                    begin
                        phase_q = half_step ? phase_q + 3'd1 : {1'b0, phase_q[1:0] + 2'd1};
                        coils_q = coil_lookup(mode_q, phase_q);
                        strobe = 1'b1;
                    end
                    else
                    begin
                        mode_q = sps_pkg::MODE_IDLE;
                        coils_q = sps_pkg::COILS_OFF;
                    end
                end
            end
            if (mode_q == sps_pkg::MODE_IDLE)
            begin
                nxt = sps_pkg::MODE_IDLE;
                if (t.cw)
                    nxt = t.sensor ? sps_pkg::MODE_HOME_CW : sps_pkg::MODE_JOG_CW;
                else if (t.ccw)
                    nxt = t.sensor ? sps_pkg::MODE_HOME_CCW : sps_pkg::MODE_JOG_CCW;
                if (nxt != sps_pkg::MODE_IDLE)
                begin
                    mode_q = nxt;
                    phase_q = '0;
                    steps_q = '0;
                    ticks_q = '0;
                    coils_q = coil_lookup(nxt, 3'd0);
                    strobe = 1'b1;
                end
                else
                    coils_q = sps_pkg::COILS_OFF;
            end
        end
        r.coil_pattern = coils_q;
        r.moving = mode_q != sps_pkg::MODE_IDLE;
        r.direction = reverse_mode(mode_q);
        r.step_strobe = strobe;
        return r;
    endfunction

    // mostly random waits, with occasional stretches of back-to-back beats
    task automatic draw_wait(inout int quiet, output int w);
        if (quiet > 0)
        begin
            quiet--;
            w = 0;
        end
        else
        begin
            if ($urandom_range(0, 39) == 0)
                quiet = $urandom_range(16, 64);
            w = $urandom_range(0, 19);
        end
    endtask

    task automatic offer_tick(input tick_t t, input logic typed,
                              input sps_pkg::sps_result_t want);
        int                   w;
        sps_pkg::sps_result_t pred;
        draw_wait(tx_quiet, w);
        if (w > 0)
        begin
            in_valid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        in_valid <= 1'b1;
        {run_enable, cw_request, ccw_request, sensor_mode, home_sensor} <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = next_coil_beat(t);
        coil_beats_due.push_back(typed ? want : pred);
    endtask

    task automatic drain_ticks();
        in_valid <= 1'b0;
        while (coil_beats_due.size() != 0)
            @(posedge clk);
    endtask

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            sps_pkg::CFG_MOTOR_TYPE:     half_step = val[0];
            sps_pkg::CFG_STEP_PERIOD_MS: period_cfg = val[9:0];
            sps_pkg::CFG_MIN_HOME_STEPS: home_min = val;
            default:                     ;
        endcase
    endtask

    task automatic apply_settings(input logic motor, input logic [9:0] period,
                                  input logic [11:0] min_home);
        drain_ticks();
        write_reg(sps_pkg::CFG_MOTOR_TYPE, {11'd0, motor});
        write_reg(sps_pkg::CFG_STEP_PERIOD_MS, {2'd0, period});
        write_reg(sps_pkg::CFG_MIN_HOME_STEPS, min_home);
        cfg_valid <= 1'b0;
    endtask

    // held levels with occasional flips give runs long enough to cross step boundaries
    function automatic tick_t make_tick(input int churn, input int noise_pct);
        if ($urandom_range(0, 99) < noise_pct)
            return tick_t'($urandom_range(0, 31));
        if (!lvl.run_enable || $urandom_range(1, 4 * churn) == 1)
            lvl.run_enable = !lvl.run_enable;
        if ($urandom_range(1, churn) == 1)
            lvl.cw = !lvl.cw;
        if ($urandom_range(1, churn) == 1)
            lvl.ccw = !lvl.ccw;
        if ($urandom_range(1, 2 * churn) == 1)
            lvl.sensor = !lvl.sensor;
        if ($urandom_range(1, churn) == 1)
            lvl.home = !lvl.home;
        return lvl;
    endfunction

    initial
    begin
        int                   w;
        int                   seen;
        sps_pkg::sps_result_t due;
        sps_pkg::sps_result_t got;
        seen = 0;
        wait (rst_n);
        forever
        begin
            // one long hold-off so the block fills up and stalls its input
            if (seen == 300)
                w = 200;
            else
                draw_wait(rx_quiet, w);
            if (w > 0)
            begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            seen++;
            got = '{coil_pattern, moving, direction, step_strobe};
            if (coil_beats_due.size() == 0)
            begin
                $error("result beat with nothing expected: %h", got);
                errors++;
            end
            else
            begin
                due = coil_beats_due.pop_front();
                if (got.coil_pattern !== due.coil_pattern)
                begin
                    $error("coil_pattern: expected %h, got %h",
                           due.coil_pattern, got.coil_pattern);
                    errors++;
                end
                if (got.moving !== due.moving)
                begin
                    $error("moving: expected %b, got %b", due.moving, got.moving);
                    errors++;
                end
                if (got.direction !== due.direction)
                begin
                    $error("direction: expected %b, got %b", due.direction, got.direction);
                    errors++;
                end
                if (got.step_strobe !== due.step_strobe)
                begin
                    $error("step_strobe: expected %b, got %b",
                           due.step_strobe, got.step_strobe);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        tick_t t;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (SCRIPT[i])
        begin
            if (SCRIPT[i].is_cfg)
            begin
                drain_ticks();
                write_reg(SCRIPT[i].reg_idx, SCRIPT[i].reg_val);
                cfg_valid <= 1'b0;
            end
            else
                offer_tick(SCRIPT[i].t, SCRIPT[i].typed, SCRIPT[i].want);
        end

        foreach (PHASES[p])
        begin
            apply_settings(PHASES[p].motor, PHASES[p].period, PHASES[p].min_home);
            repeat (PHASES[p].items)
                offer_tick(make_tick(PHASES[p].churn, PHASES[p].noise_pct), 1'b0, '0);
        end

        // over-range period: a held jog must step at 1000 ticks, not 1023
        apply_settings(1'b1, 10'd1023, 12'd0);
        repeat (1005)
        begin
            t = {2'b11, 1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1))};
            offer_tick(t, 1'b0, '0);
        end

        drain_ticks();
        repeat (4) @(posedge clk);
        if (errors == 0 && coil_beats_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/sps_pkg.sv
hw/rtl/sps_cfg_regs.sv
hw/rtl/sps_step_logic.sv
hw/rtl/stepper_phase_sequencer.sv
dv/tb_stepper_phase_sequencer.sv
